### rtl/ktb_pkg.sv
// shared types and constants for the keyed token bucket limiter
// used by the top level, the table and the divider; depends on nothing
package ktb_pkg;

    localparam int KEY_W        = 32;
    localparam int TIME_W       = 32;
    localparam int TOK_W        = 32;
    localparam int BURST_W      = 16;
    localparam int RATE_W       = 16;
    localparam int STEP_W       = 23;
    localparam int RETRY_W      = 17;
    localparam int PROD_W       = TIME_W + STEP_W;
    localparam int DIV_W        = 32;
    localparam int DVSR_W       = STEP_W;
    localparam int DCNT_W       = 6;
    localparam int STEP_RECIP_W = 30;
    localparam int STEP_PROD_W  = RATE_W + STEP_RECIP_W;
    localparam int STEP_SHIFT   = 23;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int S_DATA_W     = 64;
    localparam int M_DATA_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd2;

    localparam logic [TOK_W-1:0]  TOKEN_ONE = 32'h0001_0000;
    localparam logic [TIME_W-1:0] TIME_MAX  = 32'hFFFF_FFFF;
    localparam logic [9:0]        MS_PER_S  = 10'd1000;

    // ceil(2^39 / 1000); (rate * STEP_RECIP) >> 23 is rate * 65536 / 1000 rounded down
    // for every 16-bit rate; the product's error stays below 1/128 of a unit
    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = 30'd549755814;

    localparam logic [DCNT_W-1:0] RETRY_DIV_BITS = 6'd23;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEL,
        ST_MUL,
        ST_SAT,
        ST_SPEND,
        ST_RDIV,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
        logic [DCNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/keyed_token_bucket_limiter_unit.sv
// top level of the keyed token bucket limiter: sequencer, config and output stage
// depends on ktb_pkg, ktb_table and ktb_divider
//
// One word in is one request (client key, millisecond time) and gives one word
// out (allowed, retry delay in ms). The block handles one request at a time and
// drops s_tready from acceptance until the result is handed to the output
// register. A limited request walks the whole bucket table through its single
// read port, one entry a cycle, then goes through slot choice, the elapsed-time
// multiply, the saturating refill and the spend with write-back. A denied
// request adds the 23-step serial divide for the retry delay. A busy output
// register adds the cycles it waits on m_tready. With limiting off (enable 0,
// burst 0 or rate 0) a request goes straight to the output register and the
// table is not touched. The per-ms refill step is formed from the rate
// register by a reciprocal multiply and registered in step_reg. Any write to a
// known register clears the table at once.
module keyed_token_bucket_limiter_unit #(
    parameter int  ENTRIES = 16,
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request word
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ktb_pkg::S_DATA_W-1:0]     s_tdata,   // client_key[31:0], time_ms[63:32]
    // result word
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ktb_pkg::M_DATA_W-1:0]     m_tdata,   // allowed[0], retry_after[17:1], zeros
    // config write port
    input  logic                             cfg_wr_en,
    input  logic [ktb_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [ktb_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    ktb_pkg::state_t state_reg, state_next;

    // configuration
    logic                           enable_reg;
    logic [ktb_pkg::BURST_W-1:0]    burst_reg;
    logic [ktb_pkg::RATE_W-1:0]     rate_reg;
    logic [ktb_pkg::STEP_W-1:0]     step_reg;
    logic [ktb_pkg::STEP_PROD_W-1:0] step_prod;
    logic [ktb_pkg::STEP_W-1:0]     step_calc;
    logic                           cfg_known;
    logic                           limiter_off;
    logic [ktb_pkg::TOK_W-1:0]      cap;

    // request held during processing
    logic [ktb_pkg::KEY_W-1:0]    key_reg;
    logic [ktb_pkg::TIME_W-1:0]   now_reg;

    // table walk
    logic [CNT_W-1:0]             issue_cnt_reg;
    logic                         issue_more;
    logic                         cmp_valid_reg;
    logic [IDX_W-1:0]             cmp_idx_reg;
    logic                         hit_reg;
    logic [IDX_W-1:0]             hit_idx_reg;
    logic [ktb_pkg::TOK_W-1:0]    hit_tokens_reg;
    logic [ktb_pkg::TIME_W-1:0]   hit_time_reg;
    logic                         free_reg;
    logic [IDX_W-1:0]             free_idx_reg;
    logic [IDX_W-1:0]             old_idx_reg;
    logic [ktb_pkg::TIME_W-1:0]   old_time_reg;

    // bucket arithmetic
    logic [IDX_W-1:0]             slot_reg;
    logic [ktb_pkg::TIME_W-1:0]   delta_reg;
    logic [ktb_pkg::TOK_W-1:0]    tokens_reg;
    logic [ktb_pkg::PROD_W-1:0]   prod_reg;
    logic [ktb_pkg::PROD_W:0]     refill_sum;
    logic                         can_spend;
    logic [ktb_pkg::TOK_W-1:0]    need;
    logic [ktb_pkg::TOK_W-1:0]    need_round;

    // result staging and output register
    logic                         allowed_reg;
    logic [ktb_pkg::RETRY_W-1:0]  retry_reg;
    logic                         m_tvalid_reg;
    logic                         m_allowed_reg;
    logic [ktb_pkg::RETRY_W-1:0]  m_retry_reg;
    logic                         out_load;

    // submodule links
    logic                         accept;
    logic [IDX_W-1:0]             rd_addr;
    ktb_pkg::entry_t              rd_entry;
    logic                         rd_used;
    logic                         wr_en;
    ktb_pkg::entry_t              wr_entry;
    ktb_pkg::div_req_t            div_req;
    ktb_pkg::div_rsp_t            div_rsp;

    assign cfg_known   = cfg_wr_en && (cfg_wr_index inside
                         {ktb_pkg::REG_ENABLE, ktb_pkg::REG_BURST, ktb_pkg::REG_RATE});
    assign limiter_off = !enable_reg || (burst_reg == '0) || (rate_reg == '0);
    assign cap         = {burst_reg, 16'd0};
    assign accept      = s_tvalid && s_tready;
    assign issue_more  = issue_cnt_reg < CNT_W'(ENTRIES);
    assign refill_sum  = (ktb_pkg::PROD_W+1)'(tokens_reg) + (ktb_pkg::PROD_W+1)'(prod_reg);
    assign can_spend   = tokens_reg >= ktb_pkg::TOKEN_ONE;
    assign need        = ktb_pkg::TOKEN_ONE - tokens_reg;
    // ceiling divide: missing tokens plus step minus one, fits in 23 bits
    assign need_round  = need + ktb_pkg::TOK_W'(step_reg) - 1'b1;
    assign out_load    = (state_reg == ktb_pkg::ST_RESP) && (!m_tvalid_reg || m_tready);

    // refill step in Q16 per ms: rate * 65536 / 1000 by reciprocal multiply
    assign step_prod   = ktb_pkg::STEP_PROD_W'(rate_reg)
                         * ktb_pkg::STEP_PROD_W'(ktb_pkg::STEP_RECIP);
    assign step_calc   = step_prod[ktb_pkg::STEP_SHIFT +: ktb_pkg::STEP_W];

    ktb_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cfg_known),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_used  (rd_used),
        .wr_en    (wr_en),
        .wr_addr  (slot_reg),
        .wr_entry (wr_entry)
    );

    ktb_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            burst_reg  <= '0;
            rate_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                ktb_pkg::REG_ENABLE: enable_reg <= cfg_wr_data[0];
                ktb_pkg::REG_BURST:  burst_reg  <= cfg_wr_data;
                ktb_pkg::REG_RATE:   rate_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // step follows the rate register in the next cycle
    always_ff @(posedge aclk) begin
        // step is at least one Q16 unit per ms
        step_reg <= (step_calc == '0) ? ktb_pkg::STEP_W'(1) : step_calc;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ktb_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = limiter_off ? ktb_pkg::ST_RESP : ktb_pkg::ST_SCAN;
                end
            end
            ktb_pkg::ST_SCAN: begin
                // last entry is being compared this cycle
                if (!issue_more && cmp_valid_reg) begin
                    state_next = ktb_pkg::ST_SEL;
                end
            end
            ktb_pkg::ST_SEL:   state_next = ktb_pkg::ST_MUL;
            ktb_pkg::ST_MUL:   state_next = ktb_pkg::ST_SAT;
            ktb_pkg::ST_SAT:   state_next = ktb_pkg::ST_SPEND;
            ktb_pkg::ST_SPEND: state_next = can_spend ? ktb_pkg::ST_RESP : ktb_pkg::ST_RDIV;
            ktb_pkg::ST_RDIV: begin
                if (div_rsp.done) begin
                    state_next = ktb_pkg::ST_RESP;
                end
            end
            ktb_pkg::ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ktb_pkg::ST_IDLE;
                end
            end
            default: state_next = ktb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ktb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer outputs
    always_comb begin
        s_tready         = 1'b0;
        rd_addr          = issue_cnt_reg[IDX_W-1:0];
        wr_en            = 1'b0;
        wr_entry.key     = key_reg;
        wr_entry.tokens  = can_spend ? tokens_reg - ktb_pkg::TOKEN_ONE : tokens_reg;
        wr_entry.stamp   = now_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {need_round[ktb_pkg::STEP_W-1:0],
                            (ktb_pkg::DIV_W-ktb_pkg::STEP_W)'(0)};
        div_req.divisor  = ktb_pkg::DVSR_W'(step_reg);
        div_req.steps    = ktb_pkg::RETRY_DIV_BITS;
        unique case (state_reg)
            ktb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            ktb_pkg::ST_SPEND: begin
                wr_en         = 1'b1;
                div_req.start = !can_spend;
            end
            default: ;
        endcase
    end

    // walk control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= (state_reg == ktb_pkg::ST_SCAN) && issue_more;
        end
    end

    // request capture, table walk and bucket arithmetic
    always_ff @(posedge aclk) begin
        case (state_reg)
            ktb_pkg::ST_IDLE: begin
                key_reg       <= s_tdata[ktb_pkg::KEY_W-1:0];
                now_reg       <= s_tdata[ktb_pkg::KEY_W +: ktb_pkg::TIME_W];
                issue_cnt_reg <= '0;
                hit_reg       <= 1'b0;
                free_reg      <= 1'b0;
                old_idx_reg   <= '0;
                old_time_reg  <= ktb_pkg::TIME_MAX;
                allowed_reg   <= 1'b1;
                retry_reg     <= '0;
            end
            ktb_pkg::ST_SCAN: begin
                if (issue_more) begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                cmp_idx_reg <= issue_cnt_reg[IDX_W-1:0];
                if (cmp_valid_reg) begin
                    if (!rd_used) begin
                        // lowest free slot
                        if (!free_reg) begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= cmp_idx_reg;
                        end
                    end else begin
                        if (!hit_reg && rd_entry.key == key_reg) begin
                            hit_reg        <= 1'b1;
                            hit_idx_reg    <= cmp_idx_reg;
                            hit_tokens_reg <= rd_entry.tokens;
                            hit_time_reg   <= rd_entry.stamp;
                        end
                        // oldest stamp, lowest index on ties
                        if (rd_entry.stamp < old_time_reg) begin
                            old_time_reg <= rd_entry.stamp;
                            old_idx_reg  <= cmp_idx_reg;
                        end
                    end
                end
            end
            ktb_pkg::ST_SEL: begin
                // a fresh bucket starts full with zero elapsed time
                slot_reg   <= hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : old_idx_reg);
                tokens_reg <= hit_reg ? hit_tokens_reg : cap;
                delta_reg  <= hit_reg ? now_reg - hit_time_reg : '0;
            end
            ktb_pkg::ST_MUL: begin
                prod_reg <= ktb_pkg::PROD_W'(delta_reg) * ktb_pkg::PROD_W'(step_reg);
            end
            ktb_pkg::ST_SAT: begin
                tokens_reg <= (refill_sum > (ktb_pkg::PROD_W+1)'(cap))
                              ? cap : refill_sum[ktb_pkg::TOK_W-1:0];
            end
            ktb_pkg::ST_SPEND: begin
                allowed_reg <= can_spend;
            end
            ktb_pkg::ST_RDIV: begin
                if (div_rsp.done) begin
                    retry_reg <= div_rsp.quotient[ktb_pkg::RETRY_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_allowed_reg <= allowed_reg;
            m_retry_reg   <= retry_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(ktb_pkg::M_DATA_W-ktb_pkg::RETRY_W-1)'(0), m_retry_reg, m_allowed_reg};

endmodule

### rtl/ktb_divider.sv
// serial restoring divider, one quotient bit per cycle
// depends on ktb_pkg; the caller left-aligns the dividend bits to process
module ktb_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  ktb_pkg::div_req_t req,
    output ktb_pkg::div_rsp_t rsp
);

    logic [ktb_pkg::DIV_W-1:0]  num_reg;
    logic [ktb_pkg::DVSR_W-1:0] rem_reg;
    logic [ktb_pkg::DVSR_W-1:0] dvsr_reg;
    logic [ktb_pkg::DIV_W-1:0]  quot_reg;
    logic [ktb_pkg::DCNT_W-1:0] cnt_reg;
    logic                       run_reg;
    logic                       done_reg;

    logic [ktb_pkg::DVSR_W:0]   trial;
    logic [ktb_pkg::DVSR_W:0]   diff;
    logic                       ge;
    logic [ktb_pkg::DVSR_W-1:0] rem_next;
    logic [ktb_pkg::DIV_W-1:0]  quot_next;

    assign trial     = {rem_reg, num_reg[ktb_pkg::DIV_W-1]};
    assign ge        = trial >= {1'b0, dvsr_reg};
    assign diff      = trial - {1'b0, dvsr_reg};
    assign rem_next  = ge ? diff[ktb_pkg::DVSR_W-1:0] : trial[ktb_pkg::DVSR_W-1:0];
    assign quot_next = {quot_reg[ktb_pkg::DIV_W-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= req.steps;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ktb_pkg::DCNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg  <= req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
            quot_reg <= '0;
        end else if (run_reg) begin
            num_reg  <= {num_reg[ktb_pkg::DIV_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

### rtl/ktb_table.sv
// bucket table: key, token count and stamp memory plus per-entry used bits
// depends on ktb_pkg; one registered read port, one write port
module ktb_table #(
    parameter int  ENTRIES = 16,
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clear,
    input  logic [IDX_W-1:0]    rd_addr,
    output ktb_pkg::entry_t     rd_entry,
    output logic                rd_used,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  ktb_pkg::entry_t     wr_entry
);

    ktb_pkg::entry_t    mem [ENTRIES];
    ktb_pkg::entry_t    rd_entry_reg;
    logic               rd_used_reg;
    logic [ENTRIES-1:0] used_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
        rd_used_reg  <= used_reg[rd_addr];
    end

    // used bits clear at once on reset or any write to a known register
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            used_reg <= '0;
        end else if (wr_en) begin
            used_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_used  = rd_used_reg;

endmodule

### rtl/ktb_checker.sv
// port-level checks for the keyed token bucket limiter
// depends on the top level's ports only; bound to the top level below
module ktb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // allowed carries no delay, a deny carries a delay of 1 to 65536
    a_retry_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] ? (m_tdata[17:1] == 17'd0)
                                 : ((m_tdata[17:1] != 17'd0)
                                    && (!m_tdata[17] || (m_tdata[16:1] == 16'd0)))))
        else $error("retry delay inconsistent with allowed flag");

    // no request word is taken in the cycle after another is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request word taken back to back");

endmodule

bind keyed_token_bucket_limiter_unit ktb_checker u_ktb_checker (.*);
